// ===== rtl/bpa_pkg.sv =====
// Shared constants, codes and types for the buddy page allocator.
package bpa_pkg;

  localparam int NUM_PAGES = 1024;
  localparam int MAX_ORDER = 10;
  localparam int NORD      = MAX_ORDER + 1;
  localparam int PW        = $clog2(NUM_PAGES);
  localparam int LW        = PW + 1;
  localparam int OW        = 4;
  localparam int OIW       = $clog2(NORD);
  localparam int CW        = 11;

  localparam logic [LW-1:0] EMPTY_LINK = LW'(NUM_PAGES);

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_UNLINK,
    S_SPLIT,
    S_APP1,
    S_APP2,
    S_FMETA,
    S_FCHK,
    S_FBUD,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [OW-1:0] order;
    logic          mark;
  } meta_t;

endpackage

// ===== rtl/buddy_page_allocator_unit.sv =====
// Buddy page allocator: sequencer over page metadata and free list link memories.
//
//  channel | signals                                   | direction
//  in      | in_valid in_ready in_mode in_req_order     | in
//          | in_page_index                             |
//  out     | out_valid out_ready out_status             | out
//          | out_block_page out_block_order            |
//  cfg     | cfg_we cfg_wdata (page_count)             | in
//
// Allocate: searches the orders upward, unlinks the block found,
//   then splits it down a level at a time and hands over the result.
// Free: reads metadata, merges free buddies, appends; an ignored free skips both.
// One metadata and one link read port, both registered, set the pace.
// After reset a clearing pass over all NUM_PAGES pages runs with in_ready low.
// A waiting result stalls only the final handover.
module buddy_page_allocator_unit
  import bpa_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_mode,
  input  logic [OW-1:0]  in_req_order,
  input  logic [PW-1:0]  in_page_index,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_status,
  output logic [PW-1:0]  out_block_page,
  output logic [OW-1:0]  out_block_order,
  input  logic           cfg_we,
  input  logic [CW-1:0]  cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CW-1:0] page_count_r;
  logic [PW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          mode_r, mode_nxt;
  logic [OW-1:0] req_r, req_nxt;
  logic [PW-1:0] idx_r, idx_nxt;
  logic [OW-1:0] ord_r, ord_nxt;
  logic [PW-1:0] pg_r, pg_nxt;
  logic [PW-1:0] bud_r, bud_nxt;
  logic [PW-1:0] app_pg_r, app_pg_nxt;
  logic [LW-1:0] tail_sv_r, tail_sv_nxt;
  status_t       res_status_r, res_status_nxt;
  logic [PW-1:0] res_page_r, res_page_nxt;
  logic [OW-1:0] res_order_r, res_order_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [PW-1:0] out_page_r, out_page_nxt;
  logic [OW-1:0] out_order_r, out_order_nxt;

  logic [LW-1:0] head_r [NORD];
  logic [LW-1:0] tail_r [NORD];
  logic [LW-1:0] head_nxt [NORD];
  logic [LW-1:0] tail_nxt [NORD];

  meta_t         meta_mem [NUM_PAGES];
  logic [LW-1:0] next_mem [NUM_PAGES];
  logic [LW-1:0] prev_mem [NUM_PAGES];

  logic          meta_we, meta_re;
  logic [PW-1:0] meta_wa, meta_ra;
  meta_t         meta_wd, meta_q_r;
  logic          next_we, prev_we, link_re;
  logic [PW-1:0] next_wa, prev_wa, link_ra;
  logic [LW-1:0] next_wd, prev_wd, next_q_r, prev_q_r;

  logic [LW-1:0] cnt_eff;
  logic [OIW-1:0] oi;
  logic [LW-1:0] cur_tail;
  logic          in_acc;
  logic          out_free;
  logic [OW-1:0] ord_dn;
  logic [LW-1:0] half;
  logic [PW-1:0] bud;
  logic          bud_ok;
  logic          bud_match;
  logic [OW-1:0] meta_ord_cl;
  logic          req_big;
  logic          ord_big;

  assign cnt_eff  = (page_count_r > CW'(NUM_PAGES)) ? EMPTY_LINK : LW'(page_count_r);
  assign oi       = ord_r[OIW-1:0];
  assign cur_tail = tail_r[oi];
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign ord_dn   = ord_r - OW'(1);
  assign half     = {1'b0, pg_r} + (LW'(1) << ord_dn);
  assign bud      = pg_r ^ (PW'(1) << ord_r);
  assign bud_ok   = ({1'b0, bud} < cnt_eff);
  assign bud_match = meta_q_r.mark && (meta_q_r.order == ord_r);
  assign meta_ord_cl = (meta_q_r.order > OW'(MAX_ORDER)) ? OW'(MAX_ORDER) : meta_q_r.order;
  assign req_big  = (in_req_order > OW'(MAX_ORDER));
  assign ord_big  = (ord_r > OW'(MAX_ORDER));

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_page  = out_page_r;
  assign out_block_order = out_order_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == PW'(NUM_PAGES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_ALLOC) begin
            state_nxt = req_big ? S_RESULT : S_SEARCH;
          end else if ({1'b0, in_page_index} >= cnt_eff) begin
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_FMETA;
          end
        end
      end
      S_SEARCH: begin
        if (ord_big) state_nxt = S_RESULT;
        else if (cur_tail < EMPTY_LINK) state_nxt = S_UNLINK;
      end
      S_UNLINK: state_nxt = (mode_r == MODE_ALLOC) ? S_SPLIT : S_FCHK;
      S_SPLIT: begin
        if (ord_r > req_r) begin
          if (half < cnt_eff) state_nxt = S_APP1;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_APP1: begin
        if (cur_tail < EMPTY_LINK) state_nxt = S_APP2;
        else state_nxt = (mode_r == MODE_ALLOC) ? S_SPLIT : S_RESULT;
      end
      S_APP2: state_nxt = (mode_r == MODE_ALLOC) ? S_SPLIT : S_RESULT;
      S_FMETA: state_nxt = meta_q_r.mark ? S_RESULT : S_FCHK;
      S_FCHK: begin
        if (ord_r < OW'(MAX_ORDER) && bud_ok) state_nxt = S_FBUD;
        else state_nxt = S_APP1;
      end
      S_FBUD: state_nxt = bud_match ? S_UNLINK : S_APP1;
      S_RESULT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    mode_nxt       = mode_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    ord_nxt        = ord_r;
    pg_nxt         = pg_r;
    bud_nxt        = bud_r;
    app_pg_nxt     = app_pg_r;
    tail_sv_nxt    = tail_sv_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_order_nxt  = res_order_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_order_nxt  = out_order_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    meta_we = 1'b0; meta_wa = '0; meta_wd = '0;
    meta_re = 1'b0; meta_ra = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    link_re = 1'b0; link_ra = '0;
    case (state_r)
      S_CLEAR: begin
        meta_we     = 1'b1;
        meta_wa     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + PW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode;
          req_nxt  = in_req_order;
          idx_nxt  = in_page_index;
          ord_nxt  = in_req_order;
          if (in_mode == MODE_ALLOC) begin
            res_status_nxt = ST_NOFREE;
            res_page_nxt   = '0;
            res_order_nxt  = in_req_order;
          end else begin
            res_status_nxt = ST_IGNORED;
            res_page_nxt   = in_page_index;
            res_order_nxt  = '0;
            meta_re        = 1'b1;
            meta_ra        = in_page_index;
          end
        end
      end
      S_SEARCH: begin
        if (!ord_big) begin
          if (cur_tail < EMPTY_LINK) begin
            pg_nxt  = cur_tail[PW-1:0];
            link_re = 1'b1;
            link_ra = cur_tail[PW-1:0];
          end else begin
            ord_nxt = ord_r + OW'(1);
          end
        end
      end
      S_UNLINK: begin
        if (prev_q_r < EMPTY_LINK) begin
          next_we = 1'b1;
          next_wa = prev_q_r[PW-1:0];
          next_wd = next_q_r;
        end else begin
          head_nxt[oi] = next_q_r;
        end
        if (next_q_r < EMPTY_LINK) begin
          prev_we = 1'b1;
          prev_wa = next_q_r[PW-1:0];
          prev_wd = prev_q_r;
        end else begin
          tail_nxt[oi] = prev_q_r;
        end
        meta_we       = 1'b1;
        meta_wa       = (mode_r == MODE_ALLOC) ? pg_r : bud_r;
        meta_wd.order = ord_r;
        meta_wd.mark  = 1'b0;
        if (mode_r == MODE_FREE) begin
          if (bud_r < pg_r) pg_nxt = bud_r;
          ord_nxt = ord_r + OW'(1);
        end
      end
      S_SPLIT: begin
        if (ord_r > req_r) begin
          ord_nxt    = ord_dn;
          app_pg_nxt = half[PW-1:0];
        end else begin
          meta_we        = 1'b1;
          meta_wa        = pg_r;
          meta_wd.order  = req_r;
          meta_wd.mark   = 1'b0;
          res_status_nxt = ST_DONE;
          res_page_nxt   = pg_r;
          res_order_nxt  = req_r;
        end
      end
      S_APP1: begin
        next_we       = 1'b1;
        next_wa       = app_pg_r;
        next_wd       = EMPTY_LINK;
        prev_we       = 1'b1;
        prev_wa       = app_pg_r;
        prev_wd       = cur_tail;
        meta_we       = 1'b1;
        meta_wa       = app_pg_r;
        meta_wd.order = ord_r;
        meta_wd.mark  = 1'b1;
        if (!(cur_tail < EMPTY_LINK)) head_nxt[oi] = {1'b0, app_pg_r};
        tail_nxt[oi]  = {1'b0, app_pg_r};
        tail_sv_nxt   = cur_tail;
        res_status_nxt = ST_DONE;
        res_page_nxt   = app_pg_r;
        res_order_nxt  = ord_r;
      end
      S_APP2: begin
        next_we = 1'b1;
        next_wa = tail_sv_r[PW-1:0];
        next_wd = {1'b0, app_pg_r};
      end
      S_FMETA: begin
        if (meta_q_r.mark) begin
          res_order_nxt = meta_q_r.order;
        end else begin
          ord_nxt = meta_ord_cl;
          pg_nxt  = idx_r;
        end
      end
      S_FCHK: begin
        app_pg_nxt = pg_r;
        bud_nxt    = bud;
        if (ord_r < OW'(MAX_ORDER) && bud_ok) begin
          meta_re = 1'b1;
          meta_ra = bud;
        end
      end
      S_FBUD: begin
        if (bud_match) begin
          link_re = 1'b1;
          link_ra = bud_r;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_page_nxt   = res_page_r;
          out_order_nxt  = res_order_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
      page_count_r <= CW'(1024);
      for (int i = 0; i < NORD; i++) begin
        head_r[i] <= EMPTY_LINK;
        tail_r[i] <= EMPTY_LINK;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (cfg_we) page_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    req_r        <= req_nxt;
    idx_r        <= idx_nxt;
    ord_r        <= ord_nxt;
    pg_r         <= pg_nxt;
    bud_r        <= bud_nxt;
    app_pg_r     <= app_pg_nxt;
    tail_sv_r    <= tail_sv_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_order_r  <= res_order_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_order_r  <= out_order_nxt;
  end

  // page metadata store
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (meta_re) meta_q_r <= meta_mem[meta_ra];
  end

  // free list links
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (link_re) begin
      next_q_r <= next_mem[link_ra];
      prev_q_r <= prev_mem[link_ra];
    end
  end

  a_no_meta_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(meta_we && meta_re && (meta_wa == meta_ra)))
    else $error("metadata read and write hit the same page");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_unlink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNLINK) |-> (cur_tail < EMPTY_LINK) && !ord_big)
    else $error("unlink from an empty list");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && !out_free) |=> (state_r == S_RESULT))
    else $error("result dropped while output stalled");

endmodule

// ===== verif/buddy_page_allocator_unit_tb.sv =====
// Testbench for buddy_page_allocator_unit: directed and random traffic against a built-in predictor.
`timescale 1ns / 100ps

module buddy_page_allocator_unit_tb;
  import bpa_pkg::*;

  typedef struct {
    status_t       st;
    logic [PW-1:0] pg;
    logic [OW-1:0] ord;
  } alloc_result_t;

  typedef struct {
    int pg;
    int ord;
  } held_block_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic          in_mode;
  logic [OW-1:0] in_req_order;
  logic [PW-1:0] in_page_index;
  logic          out_valid;
  logic          out_ready;
  logic [1:0]    out_status;
  logic [PW-1:0] out_block_page;
  logic [OW-1:0] out_block_order;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  // predictor state
  logic [OW-1:0] pord [NUM_PAGES];
  bit            fmark[NUM_PAGES];
  int            nxt  [NUM_PAGES];
  int            prv  [NUM_PAGES];
  int            head [NORD];
  int            tail [NORD];
  int            page_cnt;

  alloc_result_t pending_results[$];
  held_block_t   held_blocks[$];
  int            fail_cnt;
  int            n_items;
  int            n_results;
  bit            idle_on;

  buddy_page_allocator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_req_order    (in_req_order),
    .in_page_index   (in_page_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_block_page  (out_block_page),
    .out_block_order (out_block_order),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("buddy_page_allocator_unit_tb NOT OK");
    $finish;
  end

  function automatic void list_push_tail(int o, int p);
    nxt[p] = NUM_PAGES;
    prv[p] = tail[o];
    if (tail[o] < NUM_PAGES) nxt[tail[o]] = p;
    else head[o] = p;
    tail[o]  = p;
    fmark[p] = 1'b1;
    pord[p]  = o[OW-1:0];
  endfunction

  function automatic void list_remove(int o, int p);
    int n;
    int q;
    n = nxt[p];
    q = prv[p];
    if (q < NUM_PAGES) nxt[q] = n;
    else head[o] = n;
    if (n < NUM_PAGES) prv[n] = q;
    else tail[o] = q;
    fmark[p] = 1'b0;
  endfunction

  function automatic alloc_result_t predict_step(mode_t m, int rq, int ix);
    alloc_result_t r;
    int cnt;
    int o;
    int pg;
    int b;
    bit found;
    cnt   = (page_cnt < NUM_PAGES) ? page_cnt : NUM_PAGES;
    r.st  = ST_DONE;
    r.pg  = '0;
    r.ord = '0;
    found = 1'b0;
    pg    = 0;
    if (m == MODE_ALLOC) begin
      for (o = rq; o <= MAX_ORDER; o++) begin
        if (tail[o] < NUM_PAGES) begin
          pg = tail[o];
          list_remove(o, pg);
          found = 1'b1;
          break;
        end
      end
      r.ord = rq[OW-1:0];
      if (found) begin
        while (o > rq) begin
          o--;
          // halves beyond the page count are dropped
          if (pg + (1 << o) < cnt) list_push_tail(o, pg + (1 << o));
        end
        pord[pg] = rq[OW-1:0];
        r.pg = pg[PW-1:0];
      end else begin
        r.st = ST_NOFREE;
      end
    end else if (ix >= cnt) begin
      r.st = ST_IGNORED;
      r.pg = ix[PW-1:0];
    end else if (fmark[ix]) begin
      r.st  = ST_IGNORED;
      r.pg  = ix[PW-1:0];
      r.ord = pord[ix];
    end else begin
      pg = ix;
      o  = (pord[ix] > MAX_ORDER) ? MAX_ORDER : pord[ix];
      while (o < MAX_ORDER) begin
        b = pg ^ (1 << o);
        if (b < cnt && fmark[b] && pord[b] == o) begin
          list_remove(o, b);
          if (b < pg) pg = b;
          o++;
        end else begin
          break;
        end
      end
      list_push_tail(o, pg);
      r.pg  = pg[PW-1:0];
      r.ord = o[OW-1:0];
    end
    return r;
  endfunction

  // one input transfer; returns the predicted result
  task automatic send_req(input mode_t m, input int rq, input int ix,
                          output alloc_result_t r);
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_req_order  <= rq[OW-1:0];
    in_page_index <= ix[PW-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_step(m, rq, ix);
    pending_results.push_back(r);
    n_items++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic set_page_count(input int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CW-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    page_cnt = v;
  endtask

  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer");
          fail_cnt++;
        end else begin
          alloc_result_t e;
          e = pending_results.pop_front();
          if (out_status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, out_status);
            fail_cnt++;
          end
          if (out_block_page !== e.pg) begin
            $error("block_page: expected %0d, got %0d", e.pg, out_block_page);
            fail_cnt++;
          end
          if (out_block_order !== e.ord) begin
            $error("block_order: expected %0d, got %0d", e.ord, out_block_order);
            fail_cnt++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 19);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    alloc_result_t r;
    send_req(MODE_ALLOC, 0, 0, r);
    send_req(MODE_ALLOC, 15, 1023, r);
    send_req(MODE_FREE, 0, 1023, r);
    send_req(MODE_FREE, 0, 1022, r);
    send_req(MODE_FREE, 0, 1022, r);
    send_req(MODE_ALLOC, 0, 0, r);
    send_req(MODE_ALLOC, 10, 0, r);
    for (int p = 0; p < 4; p++) send_req(MODE_FREE, 5, p, r);
    send_req(MODE_FREE, 0, 512, r);
    set_page_count(1);
    // whole split range beyond the page count
    send_req(MODE_ALLOC, 0, 0, r);
    send_req(MODE_FREE, 0, 5, r);
    send_req(MODE_FREE, 0, 0, r);
    send_req(MODE_ALLOC, 11, 0, r);
    set_page_count(3);
    send_req(MODE_FREE, 0, 1, r);
    send_req(MODE_FREE, 0, 2, r);
    send_req(MODE_ALLOC, 1, 0, r);
    send_req(MODE_ALLOC, 0, 0, r);
    send_req(MODE_FREE, 0, 2, r);
  endtask

  task automatic test_random_phase(input int cnt, input int n);
    alloc_result_t r;
    held_block_t   h;
    int            k;
    int            sel;
    int            rq;
    set_page_count(cnt);
    held_blocks.delete();
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        rq = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_ORDER) : $urandom_range(0, 3);
        send_req(MODE_ALLOC, rq, $urandom_range(0, 1023), r);
        if (r.st == ST_DONE) begin
          h.pg  = r.pg;
          h.ord = r.ord;
          held_blocks.push_back(h);
        end
      end else if (sel < 75 && held_blocks.size() != 0) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        h = held_blocks[k];
        held_blocks.delete(k);
        send_req(MODE_FREE, $urandom_range(0, 15), h.pg, r);
      end else if (sel < 92) begin
        send_req(MODE_FREE, $urandom_range(0, 15), $urandom_range(0, cnt > 1024 ? 1023 : cnt - 1), r);
      end else begin
        send_req(mode_t'($urandom_range(0, 1)), $urandom_range(0, 15),
                 $urandom_range(0, 1023), r);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_ALLOC;
    in_req_order  = '0;
    in_page_index = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    fail_cnt      = 0;
    n_items       = 0;
    n_results     = 0;
    idle_on       = 1'b1;
    page_cnt      = 1024;
    for (int i = 0; i < NUM_PAGES; i++) begin
      pord[i]  = '0;
      fmark[i] = 1'b0;
      nxt[i]   = 0;
      prv[i]   = 0;
    end
    for (int i = 0; i < NORD; i++) begin
      head[i] = NUM_PAGES;
      tail[i] = NUM_PAGES;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(1024, 150);
    test_random_phase(1, 60);
    test_random_phase(37, 120);
    test_random_phase(700, 150);
    test_random_phase($urandom_range(1, 1024), 130);
    test_random_phase(512, 120);
    idle_on = 1'b0;
    test_random_phase(1024, 150);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d requests / %0d results over seven page counts incl. 1 and 1024,",
             n_items, n_results);
    $display("with alloc/free sequences, merges, splits, exhaustion and ignored frees.");
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("buddy_page_allocator_unit_tb OK");
    end else begin
      $display("buddy_page_allocator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/buddy_page_allocator_unit.sv
verif/buddy_page_allocator_unit_tb.sv
